FILE: hw/rtl/fba_pkg.sv
package fba_pkg;

  // table geometry
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  // port field widths
  localparam int BLK_W = 4;
  localparam int AMT_W = 16;

  // compare width covers both the request and the stored capacity
  localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  // placement policy codes
  localparam logic [1:0] MODE_WORST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_FIRST = 2'd2;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // candidate token handed from cell to cell during a scan
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [1:0]           mode;
    logic [AMT_W-1:0]     amt;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] cap;
  } fba_cand_t;

  // capacity write broadcast to all cells
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic [SIZE_BITS-1:0] data;
  } fba_wr_t;

endpackage

FILE: hw/rtl/fba_cell.sv
module fba_cell import fba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  fba_wr_t          wr,
  input  fba_cand_t        cand_in,
  output fba_cand_t        cand_out
);

  logic [SIZE_BITS-1:0] cap_r;
  fba_cand_t            cand_r;
  fba_cand_t            cand_nxt;
  logic                 fits;
  logic                 take;

  // does this block hold the request, and does it beat the token
  always_comb begin
    fits = (CMP_W'(cap_r) >= CMP_W'(cand_in.amt));
    case (cand_in.mode)
      MODE_WORST: take = fits && (!cand_in.found || (cap_r > cand_in.cap));
      MODE_BEST:  take = fits && (!cand_in.found || (cap_r < cand_in.cap));
      MODE_FIRST: take = fits && !cand_in.found;
      default:    take = 1'b0;
    endcase
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.pick  = cell_idx;
      cand_nxt.cap   = cap_r;
    end
  end

  // stored capacity, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (wr.en && (wr.addr == cell_idx)) begin
      cap_r <= wr.data;
    end
  end

  // token register: valid cleared at reset, payload free running
  always_ff @(posedge clk) begin
    cand_r.found <= cand_nxt.found;
    cand_r.mode  <= cand_nxt.mode;
    cand_r.amt   <= cand_nxt.amt;
    cand_r.pick  <= cand_nxt.pick;
    cand_r.cap   <= cand_nxt.cap;
    if (!rst_n) begin
      cand_r.valid <= 1'b0;
    end else begin
      cand_r.valid <= cand_in.valid;
    end
  end

  assign cand_out = cand_r;

endmodule

FILE: hw/rtl/fit_block_allocator.sv
// fit_block_allocator: placement of allocation requests into a table of
// memory block capacities, one capacity held in each cell of a chain.
// input stream: in_tuser is the request kind (0 load, 1 allocate);
//   in_tdata carries block_index and amount. a load writes one block's
//   capacity in its transfer cycle and gives no result.
// an allocate sends a candidate token down the chain, one cell per cycle;
//   each cell compares its capacity and may take the token. after the last
//   cell the chosen block is reduced by the request and one result is
//   registered on the output stream (out_tuser granted, out_tdata block
//   and capacity left).
// path: after an allocate's transfer the token passes the register of each
//   cell in turn, is held in the result register at the chain end, and is
//   then registered in the output register that drives out_tvalid. one
//   allocate is in flight at a time: no request is taken until its result
//   has moved to the output register; while idle, loads are taken every cycle.
// the fit_mode register (cfg_wr_en, cfg_wr_data) picks worst, best or
//   first fit; the user writes it only while idle, which the block does not enforce.
// reset clears all capacities to zero and sets first fit.
// a stalled receiver holds the result in the output register; a further
//   load may still be taken, but an allocate waits at the chain end until
//   the output register frees.
module fit_block_allocator import fba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // fit_mode
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [3:0] block_index, [19:4] amount, [23:20] zero
  input  logic        in_tuser,      // [0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [3:0] chosen_block, [19:4] capacity_left, [23:20] zero
  output logic        out_tuser      // [0] granted
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } fba_state_t;

  fba_state_t           state_r, state_nxt;
  logic [1:0]           fit_mode_r;
  fba_cand_t            launch;
  fba_cand_t            cand_q [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] chain_vld;
  fba_cand_t            res_r;
  fba_wr_t              wr;
  logic                 in_xfer;
  logic                 done_fire;
  logic                 load_ok;
  logic [SIZE_BITS-1:0] cap_left;
  logic                 out_valid_r;
  logic                 out_granted_r;
  logic [BLK_W-1:0]     out_block_r;
  logic [AMT_W-1:0]     out_left_r;

  // handshake
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign load_ok   = (32'(in_tdata[3:0]) < NUM_BLOCKS);
  assign cap_left  = SIZE_BITS'(CMP_W'(res_r.cap) - CMP_W'(res_r.amt));

  // policy register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= MODE_FIRST;
    end else if (cfg_wr_en) begin
      fit_mode_r <= cfg_wr_data;
    end
  end

  // token entering the first cell
  always_comb begin
    launch.valid = in_xfer && (in_tuser == REQ_ALLOC);
    launch.found = 1'b0;
    launch.mode  = fit_mode_r;
    launch.amt   = in_tdata[19:4];
    launch.pick  = '0;
    launch.cap   = '0;
  end

  // capacity writes: loads and the write-back of a grant
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = IDX_W'(in_tdata[3:0]);
    wr.data = SIZE_BITS'(in_tdata[19:4]);
    if (in_xfer && (in_tuser == REQ_LOAD)) begin
      wr.en = load_ok;
    end else if (done_fire && res_r.found) begin
      wr.en   = 1'b1;
      wr.addr = res_r.pick;
      wr.data = cap_left;
    end
  end

  // chain of cells
  for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
    fba_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(j)),
      .wr       (wr),
      .cand_in  ((j == 0) ? launch : cand_q[(j == 0) ? 0 : j - 1]),
      .cand_out (cand_q[j])
    );
    assign chain_vld[j] = cand_q[j].valid;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (launch.valid) state_nxt = ST_SCAN;
      ST_SCAN: if (cand_q[NUM_BLOCKS-1].valid) state_nxt = ST_DONE;
      ST_DONE: if (done_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // token leaving the last cell
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && cand_q[NUM_BLOCKS-1].valid) begin
      res_r <= cand_q[NUM_BLOCKS-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_granted_r <= res_r.found;
      out_block_r   <= res_r.found ? BLK_W'(res_r.pick) : '0;
      out_left_r    <= res_r.found ? AMT_W'(cap_left) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_granted_r;
  assign out_tdata  = {4'b0, out_left_r, out_block_r};

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one token in the chain");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (chain_vld == '0))
    else $error("token in the chain while idle");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_block_r == '0 && out_left_r == '0))
    else $error("refused result carries non-zero fields");

  a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
    launch.valid |=> (state_r == ST_SCAN) && chain_vld[0])
    else $error("allocate did not enter the chain");

endmodule
